// File: sv/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Shared widths, reset values, register codes and interface types of the
// spin torque block.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int MAG_W   = 18;
  localparam int FLD_W   = 24;
  localparam int RATE_W  = 32;
  localparam int GAMMA_W = 24;
  localparam int ALPHA_W = 16;
  localparam int PREF_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd184549;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;

  // Prefactor magnitude for the reset register values, Q4.27.
  localparam logic [63:0] DEN_RESET = 64'h1_0000_0000 +
                                      64'(ALPHA_RESET) * 64'(ALPHA_RESET);
  localparam logic [63:0] NUM_RESET = 64'(GAMMA_RESET) << 39;
  localparam logic [63:0] QUOT_RESET = (NUM_RESET + (DEN_RESET >> 1)) / DEN_RESET;
  localparam logic [PREF_W-1:0] PREF_RESET = QUOT_RESET[PREF_W-1:0];

  typedef enum logic [1:0] {
    REG_GAMMA0 = 2'd0,
    REG_ALPHA0 = 2'd1,
    REG_GAMMA1 = 2'd2,
    REG_ALPHA1 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic               species;
    logic [GAMMA_W-1:0] gamma;
    logic [ALPHA_W-1:0] alpha;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              species;
    logic [PREF_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/llg_spin_torque.sv
// ----------------------------------------------------------------------------
// llg_spin_torque
// Accepts one spin per cycle while busy is low and returns it on out_strobe
// through a nine-stage multiply pipeline.
// After a configuration write, busy stays high until the prefactor of each
// written species is rebuilt by the divider at one quotient bit per cycle.
// Reset loads the default gamma and alpha and their prefactors at once.
// Results cannot be stalled; each stands on the outputs for one cycle.
// ----------------------------------------------------------------------------
module llg_spin_torque (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_species_sel,
  input  logic signed [lst_pkg::MAG_W-1:0]  in_mag_x,
  input  logic signed [lst_pkg::MAG_W-1:0]  in_mag_y,
  input  logic signed [lst_pkg::MAG_W-1:0]  in_mag_z,
  input  logic signed [lst_pkg::FLD_W-1:0]  in_field_x,
  input  logic signed [lst_pkg::FLD_W-1:0]  in_field_y,
  input  logic signed [lst_pkg::FLD_W-1:0]  in_field_z,
  output logic                              out_strobe,
  output logic signed [lst_pkg::RATE_W-1:0] out_rate_x,
  output logic signed [lst_pkg::RATE_W-1:0] out_rate_y,
  output logic signed [lst_pkg::RATE_W-1:0] out_rate_z,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [lst_pkg::ADDR_W-1:0] paddr,
  input  logic        [lst_pkg::DATA_W-1:0] pwdata,
  output logic        [lst_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  logic [lst_pkg::GAMMA_W-1:0] gamma0_r, gamma1_r;
  logic [lst_pkg::ALPHA_W-1:0] alpha0_r, alpha1_r;
  logic [lst_pkg::PREF_W-1:0]  pref0_r, pref1_r;
  logic [1:0]                  pend_r, pend_nxt;

  lst_pkg::cfg_reg_t  reg_sel;
  logic               wr_en;
  lst_pkg::div_req_t  req;
  lst_pkg::div_rsp_t  rsp;
  logic               div_busy;

  logic signed [lst_pkg::MAG_W-1:0] mag [3];
  logic signed [lst_pkg::FLD_W-1:0] fld [3];
  logic                             s_vld;
  logic signed [63:0]               s_sum [3];
  logic [lst_pkg::PREF_W-1:0]       s_pref;
  logic signed [lst_pkg::RATE_W-1:0] r_rate [3];

  assign pready  = 1'b1;
  assign reg_sel = lst_pkg::cfg_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      lst_pkg::REG_GAMMA0: prdata = {8'b0, gamma0_r};
      lst_pkg::REG_ALPHA0: prdata = {16'b0, alpha0_r};
      lst_pkg::REG_GAMMA1: prdata = {8'b0, gamma1_r};
      lst_pkg::REG_ALPHA1: prdata = {16'b0, alpha1_r};
      default:             prdata = '0;
    endcase
  end

  // Species 0 is served first when both wait for a new prefactor.
  always_comb begin
    req.valid   = !div_busy && (pend_r != 2'b00);
    req.species = !pend_r[0];
    req.gamma   = req.species ? gamma1_r : gamma0_r;
    req.alpha   = req.species ? alpha1_r : alpha0_r;
    pend_nxt    = pend_r;
    if (req.valid) begin
      pend_nxt[req.species] = 1'b0;
    end
    if (wr_en) begin
      pend_nxt[paddr[3]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma0_r <= lst_pkg::GAMMA_RESET;
      gamma1_r <= lst_pkg::GAMMA_RESET;
      alpha0_r <= lst_pkg::ALPHA_RESET;
      alpha1_r <= lst_pkg::ALPHA_RESET;
      pref0_r  <= lst_pkg::PREF_RESET;
      pref1_r  <= lst_pkg::PREF_RESET;
      pend_r   <= 2'b00;
    end else begin
      pend_r <= pend_nxt;
      if (wr_en) begin
        case (reg_sel)
          lst_pkg::REG_GAMMA0: gamma0_r <= pwdata[lst_pkg::GAMMA_W-1:0];
          lst_pkg::REG_ALPHA0: alpha0_r <= pwdata[lst_pkg::ALPHA_W-1:0];
          lst_pkg::REG_GAMMA1: gamma1_r <= pwdata[lst_pkg::GAMMA_W-1:0];
          lst_pkg::REG_ALPHA1: alpha1_r <= pwdata[lst_pkg::ALPHA_W-1:0];
          default: begin
          end
        endcase
      end
      if (rsp.done) begin
        if (rsp.species) begin
          pref1_r <= rsp.quot;
        end else begin
          pref0_r <= rsp.quot;
        end
      end
    end
  end

  assign busy = div_busy || (pend_r != 2'b00);

  lst_prefactor_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rsp      (rsp),
    .div_busy (div_busy)
  );

  assign mag[0] = in_mag_x;
  assign mag[1] = in_mag_y;
  assign mag[2] = in_mag_z;
  assign fld[0] = in_field_x;
  assign fld[1] = in_field_y;
  assign fld[2] = in_field_z;

  lst_torque_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .mag    (mag),
    .fld    (fld),
    .alpha  (in_species_sel ? alpha1_r : alpha0_r),
    .pref   (in_species_sel ? pref1_r : pref0_r),
    .s_vld  (s_vld),
    .s_sum  (s_sum),
    .s_pref (s_pref)
  );

  lst_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_vld  (s_vld),
    .s_sum  (s_sum),
    .s_pref (s_pref),
    .r_vld  (out_strobe),
    .r_rate (r_rate)
  );

  assign out_rate_x = r_rate[0];
  assign out_rate_y = r_rate[1];
  assign out_rate_z = r_rate[2];

endmodule

// File: sv/lst_prefactor_div.sv
// ----------------------------------------------------------------------------
// lst_prefactor_div
// Restoring divider for the prefactor magnitude
// round((gamma << 39) / (2^32 + alpha^2)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lst_prefactor_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lst_pkg::div_req_t req,
  output lst_pkg::div_rsp_t rsp,
  output logic              div_busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEN  = 4'b0010,
    ST_INIT = 4'b0100,
    ST_RUN  = 4'b1000
  } div_state_t;

  div_state_t                   state_r, state_nxt;
  logic                         spc_r, spc_nxt;
  logic [lst_pkg::GAMMA_W-1:0]  gamma_r, gamma_nxt;
  logic [lst_pkg::ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic [32:0]                  den_r, den_nxt;
  logic [32:0]                  rem_r, rem_nxt;
  logic [31:0]                  shf_r, shf_nxt;
  logic [lst_pkg::PREF_W-1:0]   quot_r, quot_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;

  logic [63:0] num;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    num   = {1'b0, gamma_r, 39'b0} + {31'b0, den_r[32:1]};
    trial = {rem_r, shf_r[31]};
    ge    = trial >= {1'b0, den_r};
  end

  always_comb begin
    state_nxt = state_r;
    spc_nxt   = spc_r;
    gamma_nxt = gamma_r;
    alpha_nxt = alpha_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    shf_nxt   = shf_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req.valid) begin
          spc_nxt   = req.species;
          gamma_nxt = req.gamma;
          alpha_nxt = req.alpha;
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        den_nxt   = {1'b1, 32'b0} + {1'b0, 32'(alpha_r) * 32'(alpha_r)};
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        // The quotient fits in 32 bits, so the top half is already below den.
        rem_nxt   = {1'b0, num[63:32]};
        shf_nxt   = num[31:0];
        cnt_nxt   = 5'd31;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        rem_nxt  = ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
        shf_nxt  = {shf_r[30:0], 1'b0};
        quot_nxt = {quot_r[lst_pkg::PREF_W-2:0], ge};
        if (cnt_r == 5'd0) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    spc_r   <= spc_nxt;
    gamma_r <= gamma_nxt;
    alpha_r <= alpha_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    shf_r   <= shf_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.species = spc_r;
  assign rsp.quot    = quot_r;
  // The quotient reaches the prefactor register in the cycle after done.
  assign div_busy    = (state_r != ST_IDLE) || done_r;

endmodule

// File: sv/lst_torque_pipe.sv
// ----------------------------------------------------------------------------
// lst_torque_pipe
// Six-stage pipeline forming s = (m x H) * 2^16 + alpha * round(m x (m x H) / 2^16).
// ----------------------------------------------------------------------------
module lst_torque_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [lst_pkg::MAG_W-1:0]  mag [3],
  input  logic signed [lst_pkg::FLD_W-1:0]  fld [3],
  input  logic        [lst_pkg::ALPHA_W-1:0] alpha,
  input  logic        [lst_pkg::PREF_W-1:0] pref,
  output logic                              s_vld,
  output logic signed [63:0]                s_sum [3],
  output logic        [lst_pkg::PREF_W-1:0] s_pref
);

  logic [5:0] v_r;

  logic signed [41:0] p1_r [6];
  logic signed [lst_pkg::MAG_W-1:0] m1_r [3];
  logic signed [lst_pkg::MAG_W-1:0] m2_r [3];
  logic signed [42:0] c1_2_r [3];
  logic signed [60:0] p3_r [6];
  logic signed [42:0] c1_3_r [3];
  logic signed [45:0] c2_4_r [3];
  logic signed [42:0] c1_4_r [3];
  logic signed [62:0] ac5_r [3];
  logic signed [42:0] c1_5_r [3];
  logic signed [63:0] s6_r [3];

  logic [lst_pkg::ALPHA_W-1:0] al_r [4];
  logic [lst_pkg::PREF_W-1:0]  pf_r [6];

  logic signed [41:0] p1_nxt [6];
  logic signed [42:0] c1_nxt [3];
  logic signed [60:0] p3_nxt [6];
  logic signed [45:0] c2_nxt [3];
  logic signed [61:0] d4     [3];
  logic signed [62:0] ac_nxt [3];
  logic signed [63:0] s_nxt  [3];

  // Component k of a x b is a[k+1]*b[k+2] - a[k+2]*b[k+1], indices mod 3.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    always_comb begin
      p1_nxt[2*k]   = 42'(mag[K1]) * 42'(fld[K2]);
      p1_nxt[2*k+1] = 42'(mag[K2]) * 42'(fld[K1]);
      c1_nxt[k]     = 43'(p1_r[2*k]) - 43'(p1_r[2*k+1]);
      p3_nxt[2*k]   = 61'(m2_r[K1]) * 61'(c1_2_r[K2]);
      p3_nxt[2*k+1] = 61'(m2_r[K2]) * 61'(c1_2_r[K1]);
      d4[k]         = 62'(p3_r[2*k]) - 62'(p3_r[2*k+1]);
      // Half away from zero: add one less than half when negative, then floor.
      c2_nxt[k]     = 46'((d4[k] + 62'(32768) - 62'(d4[k][61])) >>> 16);
      ac_nxt[k]     = 63'($signed({1'b0, al_r[3]})) * 63'(c2_4_r[k]);
      s_nxt[k]      = 64'($signed({c1_5_r[k], 16'b0})) + 64'(ac5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_vld};
    end
    for (int i = 0; i < 6; i++) begin
      p1_r[i] <= p1_nxt[i];
      p3_r[i] <= p3_nxt[i];
    end
    for (int i = 0; i < 3; i++) begin
      m1_r[i]   <= mag[i];
      m2_r[i]   <= m1_r[i];
      c1_2_r[i] <= c1_nxt[i];
      c1_3_r[i] <= c1_2_r[i];
      c2_4_r[i] <= c2_nxt[i];
      c1_4_r[i] <= c1_3_r[i];
      ac5_r[i]  <= ac_nxt[i];
      c1_5_r[i] <= c1_4_r[i];
      s6_r[i]   <= s_nxt[i];
    end
    al_r[0] <= alpha;
    pf_r[0] <= pref;
    for (int i = 1; i < 4; i++) begin
      al_r[i] <= al_r[i-1];
    end
    for (int i = 1; i < 6; i++) begin
      pf_r[i] <= pf_r[i-1];
    end
  end

  assign s_vld  = v_r[5];
  assign s_sum  = s6_r;
  assign s_pref = pf_r[5];

endmodule

// File: sv/lst_scale.sv
// ----------------------------------------------------------------------------
// lst_scale
// Three-stage scaling of s by the negative prefactor, with rounding and
// saturation to signed Q15.16.
// ----------------------------------------------------------------------------
module lst_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_vld,
  input  logic signed [63:0]                s_sum [3],
  input  logic        [lst_pkg::PREF_W-1:0] s_pref,
  output logic                              r_vld,
  output logic signed [lst_pkg::RATE_W-1:0] r_rate [3]
);

  logic [2:0] v_r;

  logic [62:0] us_r [3];
  logic [2:0]  neg1_r, neg2_r;
  logic [lst_pkg::PREF_W-1:0] ug_r;
  logic [63:0] lo_r [3];
  logic [62:0] hi_r [3];
  logic signed [lst_pkg::RATE_W-1:0] rate_r [3];

  logic [62:0] us_nxt [3];
  logic [94:0] tot    [3];
  logic [39:0] mag    [3];
  logic signed [lst_pkg::RATE_W-1:0] rate_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      us_nxt[k] = s_sum[k][63] ? 63'(-s_sum[k]) : s_sum[k][62:0];
      tot[k]    = {hi_r[k], 32'b0} + 95'(lo_r[k]) + (95'(1) << 54);
      mag[k]    = tot[k][94:55];
      // The prefactor is never positive, so the sign flips against s.
      if (!neg2_r[k]) begin
        if (mag[k] > 40'h80000000) begin
          rate_nxt[k] = 32'sh80000000;
        end else begin
          rate_nxt[k] = $signed(~mag[k][31:0] + 32'd1);
        end
      end else begin
        if (mag[k] > 40'h7fffffff) begin
          rate_nxt[k] = 32'sh7fffffff;
        end else begin
          rate_nxt[k] = $signed(mag[k][31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], s_vld};
    end
    ug_r <= s_pref;
    for (int k = 0; k < 3; k++) begin
      us_r[k]   <= us_nxt[k];
      neg1_r[k] <= s_sum[k][63];
      neg2_r[k] <= neg1_r[k];
      lo_r[k]   <= 64'(us_r[k][31:0]) * 64'(ug_r);
      hi_r[k]   <= 63'(us_r[k][62:32]) * 63'(ug_r);
      rate_r[k] <= rate_nxt[k];
    end
  end

  assign r_vld  = v_r[2];
  assign r_rate = rate_r;

endmodule
